[rtl/assert_macros.svh]
// Assertion helpers shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock while out of reset.
`define HMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true while out of reset.
`define HMF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define HMF_ASSERT(lbl, clk, rst_n, prop, msg)
`define HMF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/hmf_pkg.sv]
`default_nettype none

package hmf_pkg;

    // Width of the content length counter and accumulator.
    localparam int LENGTH_BITS = 32;
    // Accumulator width with headroom for one multiply-by-ten step.
    localparam int LEN_EXT_BITS = LENGTH_BITS + 4;
    localparam int OUT_LEN_BITS = 32;

    // Front-to-back queue geometry.
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    // Marker "\r\ncontent-length:" matched against lower-cased bytes.
    localparam int MARK_LEN      = 17;
    localparam int MARK_POS_BITS = 5;

    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] CHR_PLUS = 8'h2B;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_LOCKED
    } phase_t;

    typedef enum logic [2:0] {
        VS_IDLE,
        VS_LEAD,
        VS_SIGN,
        VS_DIGITS,
        VS_TRAIL,
        VS_BAD,
        VS_GOOD,
        VS_FAIL
    } value_state_t;

    // One classified byte as carried from front to back.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] lower;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_ws;
        logic       is_cr;
        logic       is_lf;
        logic       is_plus;
    } byte_class_t;

    // Marker character at a given match position.
    function automatic logic [7:0] mark_char(input logic [MARK_POS_BITS-1:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = CHR_CR;
            5'd1:    c = CHR_LF;
            5'd2:    c = "c";
            5'd3:    c = "o";
            5'd4:    c = "n";
            5'd5:    c = "t";
            5'd6:    c = "e";
            5'd7:    c = "n";
            5'd8:    c = "t";
            5'd9:    c = "-";
            5'd10:   c = "l";
            5'd11:   c = "e";
            5'd12:   c = "n";
            5'd13:   c = "g";
            5'd14:   c = "t";
            5'd15:   c = "h";
            5'd16:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/hmf_queue.sv]
`default_nettype none

module hmf_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire hmf_pkg::byte_class_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output logic                     not_empty,
    output hmf_pkg::byte_class_t     pop_data
);
    import hmf_pkg::*;

    byte_class_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0]  count_reg, count_next;

    assign full      = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`include "assert_macros.svh"
    `HMF_ASSERT_NEVER(a_no_push_full, clk, rst_n, push && full, "push into full queue")
    `HMF_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && !not_empty, "pop from empty queue")
    `HMF_ASSERT(a_count_track, clk, rst_n, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue count did not grow on push")

endmodule

`default_nettype wire

[rtl/hmf_front.sv]
`default_nettype none

module hmf_front (
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 queue_full,
    output logic                      push,
    output hmf_pkg::byte_class_t      push_data
);
    import hmf_pkg::*;

    // Take a byte whenever the queue has room
    assign req_stall = queue_full;
    assign push      = req_valid && !queue_full;

    // Classify the byte for the framer
    always_comb
    begin
        push_data.data     = data_byte;
        push_data.lower    = (data_byte inside {["A":"Z"]}) ? data_byte + 8'd32 : data_byte;
        push_data.digit    = data_byte[3:0];
        push_data.is_digit = (data_byte inside {["0":"9"]});
        push_data.is_ws    = (data_byte inside {8'h20, [8'h09:8'h0D]});
        push_data.is_cr    = (data_byte == CHR_CR);
        push_data.is_lf    = (data_byte == CHR_LF);
        push_data.is_plus  = (data_byte == CHR_PLUS);
    end

endmodule

`default_nettype wire

[rtl/hmf_back.sv]
`default_nettype none

module hmf_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 queue_not_empty,
    input  wire hmf_pkg::byte_class_t queue_data,
    output logic                      pop,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output logic [7:0]                byte_out,
    output logic                      in_body,
    output logic                      msg_last,
    output logic [31:0]               body_length,
    output logic                      length_error
);
    import hmf_pkg::*;

    phase_t                     phase_reg, phase_next;
    value_state_t               vs_reg, vs_next;
    logic [1:0]                 crlf_reg, crlf_next;
    logic [MARK_POS_BITS-1:0]   pos_reg, pos_next;
    logic [LENGTH_BITS-1:0]     acc_reg, acc_next;
    logic                       seen_reg, seen_next;
    logic [LENGTH_BITS-1:0]     left_reg, left_next;

    logic                       res_valid_reg, res_valid_next;
    logic [7:0]                 byte_out_reg;
    logic                       in_body_reg, in_body_next;
    logic                       msg_end_reg, msg_end_next;
    logic [OUT_LEN_BITS-1:0]    blen_reg, blen_next;
    logic                       err_reg, err_next;

    logic [LEN_EXT_BITS-1:0]    acc_ext;
    logic [LEN_EXT_BITS-1:0]    acc_times_ten;
    logic                       acc_ovf;
    value_state_t               digit_vs;
    logic [LENGTH_BITS-1:0]     digit_acc;
    logic                       prev_cr;
    logic [MARK_POS_BITS-1:0]   pos_inc;
    logic [LENGTH_BITS-1:0]     len_final;

    // Output register frees up when empty or taken this cycle
    assign pop = queue_not_empty && (!res_valid_reg || !res_stall);

    // acc * 10 + digit, with overflow out of LENGTH_BITS
    always_comb
    begin
        acc_ext       = LEN_EXT_BITS'(acc_reg);
        acc_times_ten = (acc_ext << 3) + (acc_ext << 1) + LEN_EXT_BITS'(queue_data.digit);
        acc_ovf       = |acc_times_ten[LEN_EXT_BITS-1:LENGTH_BITS];
        digit_vs      = acc_ovf ? VS_BAD : VS_DIGITS;
        digit_acc     = acc_ovf ? acc_reg : acc_times_ten[LENGTH_BITS-1:0];
    end

    // Framing state machine, one byte per pop
    always_comb
    begin
        phase_next     = phase_reg;
        vs_next        = vs_reg;
        crlf_next      = crlf_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        seen_next      = seen_reg;
        left_next      = left_reg;
        in_body_next   = 1'b0;
        msg_end_next   = 1'b0;
        blen_next      = '0;
        err_next       = 1'b0;
        prev_cr        = (crlf_reg == 2'd1) || (crlf_reg == 2'd3);
        pos_inc        = pos_reg + 1'b1;
        len_final      = seen_reg ? acc_reg : '0;
        res_valid_next = pop ? 1'b1 : (res_valid_reg && res_stall);

        if (pop)
        begin
            case (phase_reg)
                PH_LOCKED:
                begin
                    err_next = 1'b1;
                end
                PH_BODY:
                begin
                    in_body_next = 1'b1;
                    if (left_reg <= LENGTH_BITS'(1))
                    begin
                        left_next    = '0;
                        msg_end_next = 1'b1;
                        phase_next   = PH_HEADER;
                    end
                    else
                    begin
                        left_next = left_reg - 1'b1;
                    end
                end
                PH_HEADER:
                begin
                    if (crlf_reg == 2'd3 && queue_data.is_lf)
                    begin
                        // Blank line: headers done
                        if (seen_reg && vs_reg != VS_GOOD)
                        begin
                            err_next   = 1'b1;
                            phase_next = PH_LOCKED;
                        end
                        else
                        begin
                            blen_next = OUT_LEN_BITS'(len_final);
                            if (len_final == '0)
                            begin
                                msg_end_next = 1'b1;
                            end
                            else
                            begin
                                left_next  = len_final;
                                phase_next = PH_BODY;
                            end
                        end
                        crlf_next = '0;
                        pos_next  = '0;
                        vs_next   = VS_IDLE;
                        acc_next  = '0;
                        seen_next = 1'b0;
                    end
                    else
                    begin
                        if (vs_reg inside {VS_LEAD, VS_SIGN, VS_DIGITS, VS_TRAIL, VS_BAD})
                        begin
                            // Value parsing
                            if (queue_data.is_lf && prev_cr)
                            begin
                                vs_next = (vs_reg == VS_DIGITS || vs_reg == VS_TRAIL)
                                          ? VS_GOOD : VS_FAIL;
                            end
                            else
                            begin
                                case (vs_reg)
                                    VS_LEAD:
                                    begin
                                        if (queue_data.is_digit)
                                        begin
                                            vs_next  = digit_vs;
                                            acc_next = digit_acc;
                                        end
                                        else if (queue_data.is_plus)
                                        begin
                                            vs_next = VS_SIGN;
                                        end
                                        else if (!queue_data.is_ws)
                                        begin
                                            vs_next = VS_BAD;
                                        end
                                    end
                                    VS_SIGN:
                                    begin
                                        if (queue_data.is_digit)
                                        begin
                                            vs_next  = digit_vs;
                                            acc_next = digit_acc;
                                        end
                                        else
                                        begin
                                            vs_next = VS_BAD;
                                        end
                                    end
                                    VS_DIGITS:
                                    begin
                                        if (queue_data.is_digit)
                                        begin
                                            vs_next  = digit_vs;
                                            acc_next = digit_acc;
                                        end
                                        else
                                        begin
                                            vs_next = queue_data.is_ws ? VS_TRAIL : VS_BAD;
                                        end
                                    end
                                    VS_TRAIL:
                                    begin
                                        if (!queue_data.is_ws)
                                        begin
                                            vs_next = VS_BAD;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                        else if (!seen_reg)
                        begin
                            // Header name matching
                            if (queue_data.lower == mark_char(pos_reg))
                            begin
                                if (pos_inc == MARK_POS_BITS'(MARK_LEN))
                                begin
                                    pos_next  = '0;
                                    seen_next = 1'b1;
                                    acc_next  = '0;
                                    vs_next   = VS_LEAD;
                                end
                                else
                                begin
                                    pos_next = pos_inc;
                                end
                            end
                            else
                            begin
                                pos_next = queue_data.is_cr ? MARK_POS_BITS'(1) : '0;
                            end
                        end

                        // CR LF CR LF tracking
                        if (queue_data.is_cr)
                        begin
                            crlf_next = (crlf_reg == 2'd2) ? 2'd3 : 2'd1;
                        end
                        else if (queue_data.is_lf && crlf_reg == 2'd1)
                        begin
                            crlf_next = 2'd2;
                        end
                        else
                        begin
                            crlf_next = 2'd0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            vs_reg        <= VS_IDLE;
            crlf_reg      <= '0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            left_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            vs_reg        <= vs_next;
            crlf_reg      <= crlf_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            left_reg      <= left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload, loaded on each pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_out_reg <= queue_data.data;
            in_body_reg  <= in_body_next;
            msg_end_reg  <= msg_end_next;
            blen_reg     <= blen_next;
            err_reg      <= err_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign byte_out     = byte_out_reg;
    assign in_body      = in_body_reg;
    assign msg_last     = msg_end_reg;
    assign body_length  = blen_reg;
    assign length_error = err_reg;

`include "assert_macros.svh"
    `HMF_ASSERT(a_lock_sticks, clk, rst_n, (phase_reg == PH_LOCKED) |=> (phase_reg == PH_LOCKED), "error lock released")
    `HMF_ASSERT_NEVER(a_body_nonzero, clk, rst_n, (phase_reg == PH_BODY) && (left_reg == '0), "body phase with no bytes left")
    `HMF_ASSERT_NEVER(a_err_clean, clk, rst_n, res_valid_reg && err_reg && (in_body_reg || msg_end_reg), "error result carries framing marks")
    `HMF_ASSERT_NEVER(a_pos_range, clk, rst_n, pos_reg >= MARK_POS_BITS'(MARK_LEN), "marker position out of range")

endmodule

`default_nettype wire

[rtl/http_message_framer_unit.sv]
// HTTP/1.1 message framer (Content-Length framing).
// Input channel: req_valid / req_stall / data_byte, one request byte per transaction.
// Output channel: res_valid / res_stall with byte_out, in_body, msg_last,
//   body_length and length_error; exactly one result transaction per input byte.
// The front classifies each byte and writes it into a 4-entry queue; the back
// pops the queue, runs header matching, length parsing and body counting,
// and loads the output register.
// An accepted byte is registered in a queue slot, then popped into the output register.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// combinational back state update (one multiply-by-ten and add per digit).
// Reset: queue emptied, output invalid, header tracking cleared, error lock released.
// When the receiver stalls, the output register holds its transaction, the queue
// absorbs up to four more bytes, then req_stall rises until room frees up.
// A malformed or oversized length locks the framer: every later byte passes
// through with length_error set until reset.
`default_nettype none

module http_message_framer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [7:0]  data_byte,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [7:0]       byte_out,
    output logic             in_body,
    output logic             msg_last,
    output logic [31:0]      body_length,
    output logic             length_error
);
    import hmf_pkg::*;

    logic         push;
    byte_class_t  push_data;
    logic         queue_full;
    logic         pop;
    logic         queue_not_empty;
    byte_class_t  queue_data;

    hmf_front u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .data_byte  (data_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    hmf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_data  (queue_data)
    );

    hmf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .queue_data      (queue_data),
        .pop             (pop),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .byte_out        (byte_out),
        .in_body         (in_body),
        .msg_last        (msg_last),
        .body_length     (body_length),
        .length_error    (length_error)
    );

endmodule

`default_nettype wire

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmf_pkg::*;

    localparam int RANDOM_BYTES = 1150;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTED  = 100;

    // Largest length the block accepts
    localparam logic [63:0] LEN_CEIL = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LENGTH_BITS);

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_UZ    = "Z";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LZ    = "z";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_BURST
    } stall_mode_t;

    // One framed byte as the block should present it
    typedef struct packed {
        logic [7:0]  data;
        logic        body;
        logic        last;
        logic [31:0] blen;
        logic        err;
    } frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [7:0]  byte_out;
    logic        in_body;
    logic        msg_last;
    logic [31:0] body_length;
    logic        length_error;

    logic [7:0]  request_bytes[$];
    frame_t      expected_frames[$];

    int          mismatches = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    logic [7:0]  stall_tick = 8'd0;
    stall_mode_t stall_mode = STALL_NONE;
    logic [15:0] stall_pat = 16'd0;
    logic [4:0]  stall_cut = 5'd0;

    // Framer state as the predictor tracks it
    phase_t       framer_phase = PH_HEADER;
    logic [1:0]   crlf_progress = 2'd0;
    int           mark_idx = 0;
    value_state_t value_st = VS_IDLE;
    logic [63:0]  length_sum = 64'd0;
    logic         length_found = 1'b0;
    logic [63:0]  body_remaining = 64'd0;
    string        hdr_name = "content-length:";

    http_message_framer_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .data_byte    (data_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .byte_out     (byte_out),
        .in_body      (in_body),
        .msg_last     (msg_last),
        .body_length  (body_length),
        .length_error (length_error)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Append one decimal digit, refusing anything past the length width
    function automatic value_state_t accumulate_digit(logic [7:0] b);
        logic [63:0] d;
        d = {56'd0, b - CH_ZERO};
        if (length_sum > (LEN_CEIL - d) / 10)
            return VS_BAD;
        length_sum = length_sum * 10 + d;
        return VS_DIGITS;
    endfunction

    // Advance the framer by one byte and return the marks it should carry
    function automatic frame_t frame_byte(logic [7:0] b);
        frame_t     r;
        logic [7:0] lc;
        logic [7:0] want;
        logic       ws;
        logic       dig;
        logic       prev_cr;
        r.data = b;
        r.body = 1'b0;
        r.last = 1'b0;
        r.blen = 32'd0;
        r.err  = 1'b0;
        ws  = (b == CH_SP) || (b >= CH_HT && b <= CHR_CR);
        dig = (b >= CH_ZERO) && (b <= CH_NINE);
        if (framer_phase == PH_LOCKED)
            r.err = 1'b1;
        else if (framer_phase == PH_BODY)
        begin
            r.body = 1'b1;
            if (body_remaining <= 64'd1)
            begin
                body_remaining = 64'd0;
                r.last = 1'b1;
                framer_phase = PH_HEADER;
            end
            else
                body_remaining = body_remaining - 64'd1;
        end
        else if (crlf_progress == 2'd3 && b == CHR_LF)
        begin
            // blank line: settle the length, then start the next header block fresh
            if (length_found && value_st != VS_GOOD)
            begin
                r.err = 1'b1;
                framer_phase = PH_LOCKED;
            end
            else if (!length_found || length_sum == 64'd0)
                r.last = 1'b1;
            else
            begin
                r.blen = length_sum[31:0];
                body_remaining = length_sum;
                framer_phase = PH_BODY;
            end
            crlf_progress = 2'd0;
            mark_idx = 0;
            value_st = VS_IDLE;
            length_sum = 64'd0;
            length_found = 1'b0;
        end
        else
        begin
            // odd progress means the previous byte was a CR
            prev_cr = crlf_progress[0];
            if (value_st >= VS_LEAD && value_st <= VS_BAD)
            begin
                if (b == CHR_LF && prev_cr)
                    value_st = (value_st == VS_DIGITS || value_st == VS_TRAIL) ?
                               VS_GOOD : VS_FAIL;
                else
                    case (value_st)
                        VS_LEAD:
                        begin
                            if (dig)
                                value_st = accumulate_digit(b);
                            else if (b == CHR_PLUS)
                                value_st = VS_SIGN;
                            else if (!ws)
                                value_st = VS_BAD;
                        end
                        VS_SIGN:   value_st = dig ? accumulate_digit(b) : VS_BAD;
                        VS_DIGITS:
                        begin
                            if (dig)
                                value_st = accumulate_digit(b);
                            else
                                value_st = ws ? VS_TRAIL : VS_BAD;
                        end
                        VS_TRAIL:
                        begin
                            if (!ws)
                                value_st = VS_BAD;
                        end
                        default: ;
                    endcase
            end
            else if (!length_found)
            begin
                // case-blind match of CR LF followed by the field name
                lc = (b >= CH_UA && b <= CH_UZ) ? (b | CASE_BIT) : b;
                if (mark_idx == 0)
                    want = CHR_CR;
                else if (mark_idx == 1)
                    want = CHR_LF;
                else
                    want = hdr_name[mark_idx - 2];
                if (mark_idx < MARK_LEN && lc == want)
                    mark_idx = mark_idx + 1;
                else
                    mark_idx = (lc == CHR_CR) ? 1 : 0;
                if (mark_idx >= MARK_LEN)
                begin
                    mark_idx = 0;
                    length_found = 1'b1;
                    length_sum = 64'd0;
                    value_st = VS_LEAD;
                end
            end
            if (b == CHR_CR)
                crlf_progress = (crlf_progress == 2'd2) ? 2'd3 : 2'd1;
            else if (b == CHR_LF && crlf_progress == 2'd1)
                crlf_progress = 2'd2;
            else
                crlf_progress = 2'd0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (mismatches < MAX_PRINTED)
            $display("tb: %s mismatch at result %0d: got %0h, expected %0h",
                     field, results_seen, got, want);
        mismatches++;
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            request_bytes.push_back(s[i]);
    endtask

    task automatic put_line_break();
        request_bytes.push_back(CHR_CR);
        request_bytes.push_back(CHR_LF);
    endtask

    task automatic put_body(int n);
        for (int i = 0; i < n; i++)
            request_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Letters flip to upper case at random
    task automatic put_mixed_case(string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= CH_LA && c <= CH_LZ && $urandom_range(0, 1) == 1)
                c = c - CASE_BIT;
            request_bytes.push_back(c);
        end
    endtask

    task automatic put_length_line(string value);
        put_line_break();
        put_mixed_case("content-length");
        put_text(":");
        put_text(value);
    endtask

    // Length value with random padding, sign and leading zeros
    function automatic string length_value(longint unsigned len);
        string s;
        case ($urandom_range(0, 7))
            0:       s = "";
            1:       s = "\011";
            2:       s = " \011 ";
            3:       s = "\013\014 ";
            4:       s = "\n ";
            5:       s = " \015 ";
            default: s = " ";
        endcase
        if ($urandom_range(0, 3) == 0)
            s = {s, "+"};
        if ($urandom_range(0, 5) == 0)
            s = {s, "00"};
        s = {s, $sformatf("%0d", len)};
        case ($urandom_range(0, 5))
            0:       s = {s, " "};
            1:       s = {s, "\011\014"};
            default: ;
        endcase
        return s;
    endfunction

    // Filler header line; never holds a CR LF pair of its own
    task automatic put_noise_line();
        int         n;
        logic [7:0] c;
        put_line_break();
        if ($urandom_range(0, 9) == 0)
            put_text("X-Content-Length: 12");
        else
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                c = CH_LA + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 1) == 1)
                    c = c - CASE_BIT;
                request_bytes.push_back(c);
            end
            put_text(": ");
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 11))
                    0: c = 8'($urandom_range(128, 255));
                    1:
                    begin
                        c = 8'($urandom_range(0, 31));
                        if (c == CHR_CR || c == CHR_LF)
                            c = CH_SP;
                    end
                    2:
                    begin
                        // lone CR
                        request_bytes.push_back(CHR_CR);
                        c = CH_X;
                    end
                    3:       c = CHR_LF;
                    default: c = 8'($urandom_range(33, 126));
                endcase
                request_bytes.push_back(c);
            end
        end
    endtask

    task automatic put_request_line();
        case ($urandom_range(0, 19))
            // field name at message start has no line break ahead of it
            0:          put_text("Content-Length: 5");
            1, 2, 3:    put_text("POST /form HTTP/1.1");
            4, 5:       put_text("PUT /x HTTP/1.0");
            default:    put_text("GET / HTTP/1.1");
        endcase
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                expected_frames.push_back(frame_byte(data_byte));
            if (!(req_valid && req_stall))
            begin
                if (gap_left != 0)
                begin
                    req_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (request_bytes.size() != 0)
                begin
                    req_valid <= 1'b1;
                    data_byte <= request_bytes.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, switching style each time the 8-bit tick counter wraps
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 8'd1;
        if (stall_tick == 8'd0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_pat <= 16'($urandom);
            stall_cut <= 5'($urandom_range(1, 31));
        end
        case (stall_mode)
            STALL_NONE:    res_stall <= 1'b0;
            STALL_RANDOM:  res_stall <= ($urandom_range(0, 2) == 0);
            STALL_PATTERN: res_stall <= stall_pat[stall_tick[3:0]];
            default:       res_stall <= (stall_tick[4:0] >= stall_cut);
        endcase
    end

    // Result checker
    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_frames.size() == 0)
                report_mismatch("unexpected transaction, byte_out", 32'(byte_out), 32'd0);
            else
            begin
                want = expected_frames.pop_front();
                if (byte_out !== want.data)
                    report_mismatch("byte_out", 32'(byte_out), 32'(want.data));
                if (in_body !== want.body)
                    report_mismatch("in_body", 32'(in_body), 32'(want.body));
                if (msg_last !== want.last)
                    report_mismatch("msg_last", 32'(msg_last), 32'(want.last));
                if (body_length !== want.blen)
                    report_mismatch("body_length", body_length, want.blen);
                if (length_error !== want.err)
                    report_mismatch("length_error", 32'(length_error), 32'(want.err));
            end
            results_seen++;
        end
    end

    // Cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int  directed_total;
        int  hdr_count;
        int  len_at;
        int  blen;
        bit  has_len;

        // header block with no length field: empty body
        put_text("GET / HTTP/1.1");
        put_line_break();
        put_line_break();
        // zero length closes the message on the blank line
        put_text("GET /a HTTP/1.1");
        put_length_line(" 0");
        put_line_break();
        put_line_break();
        // upper-case name, no padding, extreme body bytes
        put_text("POST /b HTTP/1.1");
        put_line_break();
        put_text("CONTENT-LENGTH:5");
        put_line_break();
        put_line_break();
        request_bytes.push_back(8'h00);
        request_bytes.push_back(8'hFF);
        request_bytes.push_back(CHR_CR);
        request_bytes.push_back(CHR_LF);
        request_bytes.push_back(8'h80);
        // next message: the field at its very start has no line break of its own
        put_text("Content-Length: 3");
        put_line_break();
        put_line_break();
        // every whitespace kind around a signed value with leading zeros
        put_text("PUT /c HTTP/1.1");
        put_length_line(" \n\011\013\014\015 +0007 \011\014");
        put_line_break();
        put_line_break();
        put_body(7);
        // only the first length field counts
        put_text("GET /d HTTP/1.1");
        put_length_line(" 2");
        put_length_line(" 9");
        put_line_break();
        put_line_break();
        put_body(2);
        // a name that merely ends in the field name is not a match
        put_text("GET /e HTTP/1.1");
        put_line_break();
        put_text("X-Content-Length: 4");
        put_line_break();
        put_line_break();
        // long run of leading zeros stays in range
        put_text("GET /g HTTP/1.1");
        put_length_line("000000000000000000001");
        put_line_break();
        put_line_break();
        put_body(1);
        // stray CR and LF bytes inside the header block
        put_text("GET /f HTTP/1.1\n");
        put_length_line(" 4");
        request_bytes.push_back(CHR_CR);
        put_line_break();
        put_line_break();
        put_body(4);
        directed_total = request_bytes.size();

        // random requests, mostly well formed
        while (request_bytes.size() < directed_total + RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                for (int i = $urandom_range(1, 4); i > 0; i--)
                    request_bytes.push_back(8'($urandom_range(33, 126)));
            put_request_line();
            hdr_count = $urandom_range(0, 4);
            len_at = $urandom_range(0, hdr_count);
            has_len = ($urandom_range(0, 7) != 0);
            blen = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 300) :
                                                  $urandom_range(0, 24);
            for (int h = 0; h <= hdr_count; h++)
                if (has_len && h == len_at)
                    put_length_line(length_value(64'(blen)));
                else
                    put_noise_line();
            if (has_len && $urandom_range(0, 7) == 0)
                put_length_line(length_value(64'($urandom_range(0, 99))));
            put_line_break();
            put_line_break();
            if (has_len)
                put_body(blen);
        end

        // last request leaves the block locked or inside a huge body
        put_text("POST /z HTTP/1.1");
        case ($urandom_range(0, 11))
            0, 1, 2, 3: put_length_line(" +4294967295 ");
            4:          put_length_line(" 4294967296");
            5:          put_length_line("");
            6:          put_length_line(" +");
            7:          put_length_line(" -5");
            8:          put_length_line(" 1 2");
            9:          put_length_line(" 12a");
            10:         put_length_line(" 99999999999999999999");
            default:    put_length_line(" 1\0152");
        endcase
        put_line_break();
        put_line_break();
        put_body(32);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (request_bytes.size() != 0 || req_valid || expected_frames.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[http_message_framer_unit.f]
+incdir+rtl
rtl/hmf_pkg.sv
rtl/hmf_queue.sv
rtl/hmf_front.sv
rtl/hmf_back.sv
rtl/http_message_framer_unit.sv
sim/tb.sv
